/* hdl/tbrl_pkg.sv */
package tbrl_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned TOK_W  = 62;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W  = 95;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned IDX_W  = 1;

  localparam logic [DATA_W-1:0] SCALE           = 32'd1000000000;
  // floor(2^61 / 1e9)
  localparam logic [DATA_W-1:0] RECIP_SCALE     = 32'd2305843009;
  localparam logic [TIME_W-1:0] TIME_MAX        = '1;
  localparam logic [CNT_W-1:0]  DIV_RATE_STEPS  = 6'd62;

  localparam logic [IDX_W-1:0] REG_RATE = 1'b0;
  localparam logic [IDX_W-1:0] REG_CAP  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_REFILL  = 2'd0,
    OP_CONSUME = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_SET_START,
    CMD_TOUCH,
    CMD_FILL,
    CMD_PREP,
    CMD_MUL_LO,
    CMD_MUL_HI,
    CMD_SUM,
    CMD_RF_UPD,
    CMD_MUL_BYTES,
    CMD_CONSUME,
    CMD_Q_NOW,
    CMD_Q_NEVER,
    CMD_DIV_RATE,
    CMD_Q_SUM,
    CMD_CONV_EST,
    CMD_CONV_MUL,
    CMD_CONV_SUB,
    CMD_CONV_FIX,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    started;
    logic    now_gt_last;
    logic    rate_zero;
    logic    cap_zero;
    logic    tok_full;
    logic    bytes_zero;
    logic    want_fits;
    logic    div_done;
    logic    conv_fit;
  } dp_stat_t;

endpackage

/* hdl/tbrl_div.sv */
module tbrl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tbrl_pkg::TOK_W-1:0]  dvd_in,
  input  logic [tbrl_pkg::DATA_W-1:0] rem_in,
  input  logic [tbrl_pkg::DATA_W-1:0] dvs_in,
  input  logic [tbrl_pkg::CNT_W-1:0]  steps_in,
  output logic                        done,
  output logic [tbrl_pkg::TOK_W-1:0]  quo,
  output logic [tbrl_pkg::DATA_W-1:0] rem
);
  import tbrl_pkg::*;

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TOK_W-1:0]  dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, dvd_r[TOK_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps_in;
      dvd_nxt  = dvd_in;
      rem_nxt  = rem_in;
      dvs_nxt  = dvs_in;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dvd_nxt = {dvd_r[TOK_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = busy_r && (cnt_r == CNT_W'(1));
  assign quo  = dvd_r;
  assign rem  = rem_r;

endmodule

/* hdl/tbrl_dp.sv */
module tbrl_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tbrl_pkg::cmd_t              cmd,
  output tbrl_pkg::dp_stat_t          stat,
  input  logic                        cfg_we,
  input  logic [tbrl_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tbrl_pkg::DATA_W-1:0] cfg_wdata,
  input  logic [tbrl_pkg::OP_W-1:0]   in_opcode,
  input  logic [tbrl_pkg::TIME_W-1:0] in_now_ns,
  input  logic [tbrl_pkg::DATA_W-1:0] in_byte_count,
  output logic [tbrl_pkg::DATA_W-1:0] out_available_bytes,
  output logic [tbrl_pkg::TIME_W-1:0] out_eligible_ns,
  output logic                        out_never_eligible
);
  import tbrl_pkg::*;

  logic [DATA_W-1:0] rate_r, rate_nxt;
  logic [DATA_W-1:0] cap_r, cap_nxt;
  logic [TOK_W-1:0]  cap_lvl_r, cap_lvl_nxt;
  logic [TOK_W-1:0]  tokens_r, tokens_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic              started_r, started_nxt;

  opcode_t           op_r, op_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [DATA_W-1:0] bytes_r, bytes_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [TOK_W-1:0]  room_r, room_nxt;
  logic [PROD_W-1:0] plo_r, plo_nxt;
  logic [PROD_W-1:0] phi_r, phi_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [TIME_W-1:0] elig_r, elig_nxt;
  logic              never_r, never_nxt;
  logic [DATA_W-1:0] conv_q_r, conv_q_nxt;
  logic [DATA_W:0]   conv_rem_r, conv_rem_nxt;

  logic [DATA_W-1:0] avail_out_r, avail_out_nxt;
  logic [TIME_W-1:0] elig_out_r, elig_out_nxt;
  logic              never_out_r, never_out_nxt;

  logic [DATA_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] wait_sum;
  logic [TOK_W-1:0]  conv_diff;

  logic              div_start;
  logic [TOK_W-1:0]  div_dvd;
  logic [DATA_W-1:0] div_rem_in;
  logic [DATA_W-1:0] div_dvs;
  logic [CNT_W-1:0]  div_steps;
  logic              div_done;
  logic [TOK_W-1:0]  div_quo;
  logic [DATA_W-1:0] div_rem;

  // one shared 32x32 multiplier
  always_comb begin
    mul_a = bytes_r;
    mul_b = SCALE;
    if (cfg_we && (cfg_index == REG_CAP)) begin
      mul_a = cfg_wdata;
    end else begin
      case (cmd)
        CMD_MUL_LO: begin
          mul_a = elapsed_r[DATA_W-1:0];
          mul_b = rate_r;
        end
        CMD_MUL_HI: begin
          mul_a = {1'b0, elapsed_r[TIME_W-1:DATA_W]};
          mul_b = rate_r;
        end
        CMD_CONV_EST: begin
          mul_a = tokens_r[TOK_W-1:TOK_W-DATA_W];
          mul_b = RECIP_SCALE;
        end
        CMD_CONV_MUL: begin
          mul_a = conv_q_r;
          mul_b = SCALE;
        end
        default: begin
          mul_a = bytes_r;
          mul_b = SCALE;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  assign wait_sum = {1'b0, now_r} + {2'b00, div_quo} + PROD_W'(div_rem != '0);

  // tokens / 1e9: reciprocal estimate is low by at most four
  assign conv_diff = tokens_r - plo_r[TOK_W-1:0];

  assign div_start  = (cmd == CMD_DIV_RATE);
  assign div_dvd    = plo_r[TOK_W-1:0] - tokens_r;
  assign div_rem_in = '0;
  assign div_dvs    = rate_r;
  assign div_steps  = DIV_RATE_STEPS;

  tbrl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dvd_in   (div_dvd),
    .rem_in   (div_rem_in),
    .dvs_in   (div_dvs),
    .steps_in (div_steps),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    rate_nxt      = rate_r;
    cap_nxt       = cap_r;
    cap_lvl_nxt   = cap_lvl_r;
    tokens_nxt    = tokens_r;
    last_nxt      = last_r;
    started_nxt   = started_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    bytes_nxt     = bytes_r;
    elapsed_nxt   = elapsed_r;
    room_nxt      = room_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    acc_nxt       = acc_r;
    elig_nxt      = elig_r;
    never_nxt     = never_r;
    conv_q_nxt    = conv_q_r;
    conv_rem_nxt  = conv_rem_r;
    avail_out_nxt = avail_out_r;
    elig_out_nxt  = elig_out_r;
    never_out_nxt = never_out_r;

    case (cmd)
      CMD_CAPTURE: begin
        op_nxt    = opcode_t'(in_opcode);
        now_nxt   = in_now_ns;
        bytes_nxt = in_byte_count;
        elig_nxt  = '0;
        never_nxt = 1'b0;
      end
      CMD_SET_START: begin
        last_nxt    = now_r;
        started_nxt = 1'b1;
      end
      CMD_TOUCH: begin
        if (now_r > last_r) begin
          last_nxt = now_r;
        end
      end
      CMD_FILL: begin
        tokens_nxt = cap_lvl_r;
        last_nxt   = now_r;
      end
      CMD_PREP: begin
        elapsed_nxt = now_r - last_r;
        room_nxt    = cap_lvl_r - tokens_r;
      end
      CMD_MUL_LO: begin
        plo_nxt = mul_p;
      end
      CMD_MUL_HI: begin
        phi_nxt = mul_p;
      end
      CMD_SUM: begin
        acc_nxt = {{(ACC_W-PROD_W){1'b0}}, plo_r}
                + {phi_r[PROD_W-2:0], {DATA_W{1'b0}}};
      end
      CMD_RF_UPD: begin
        // elapsed * rate > room  <=>  elapsed > room / rate
        if (acc_r > {{(ACC_W-TOK_W){1'b0}}, room_r}) begin
          tokens_nxt = cap_lvl_r;
        end else begin
          tokens_nxt = tokens_r + acc_r[TOK_W-1:0];
        end
        last_nxt = now_r;
      end
      CMD_MUL_BYTES: begin
        plo_nxt = mul_p;
      end
      CMD_CONSUME: begin
        if (plo_r >= {2'b00, tokens_r}) begin
          tokens_nxt = '0;
        end else begin
          tokens_nxt = tokens_r - plo_r[TOK_W-1:0];
        end
      end
      CMD_Q_NOW: begin
        elig_nxt = now_r;
      end
      CMD_Q_NEVER: begin
        never_nxt = 1'b1;
        elig_nxt  = TIME_MAX;
      end
      CMD_Q_SUM: begin
        elig_nxt = wait_sum[PROD_W-1] ? TIME_MAX : wait_sum[TIME_W-1:0];
      end
      CMD_CONV_EST: begin
        conv_q_nxt = mul_p[2*DATA_W-2:DATA_W-1];
      end
      CMD_CONV_MUL: begin
        plo_nxt = mul_p;
      end
      CMD_CONV_SUB: begin
        conv_rem_nxt = conv_diff[DATA_W:0];
      end
      CMD_CONV_FIX: begin
        conv_rem_nxt = conv_rem_r - {1'b0, SCALE};
        conv_q_nxt   = conv_q_r + DATA_W'(1);
      end
      CMD_OUT: begin
        avail_out_nxt = conv_q_r;
        elig_out_nxt  = elig_r;
        never_out_nxt = never_r;
      end
      default: begin
        op_nxt = op_r;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_RATE: begin
          rate_nxt   = cfg_wdata;
          tokens_nxt = cap_lvl_r;
        end
        REG_CAP: begin
          cap_nxt     = cfg_wdata;
          cap_lvl_nxt = mul_p[TOK_W-1:0];
          tokens_nxt  = mul_p[TOK_W-1:0];
        end
        default: begin
          rate_nxt = rate_r;
        end
      endcase
      last_nxt    = '0;
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= '0;
      cap_r     <= '0;
      cap_lvl_r <= '0;
      tokens_r  <= '0;
      last_r    <= '0;
      started_r <= 1'b0;
    end else begin
      rate_r    <= rate_nxt;
      cap_r     <= cap_nxt;
      cap_lvl_r <= cap_lvl_nxt;
      tokens_r  <= tokens_nxt;
      last_r    <= last_nxt;
      started_r <= started_nxt;
    end
    op_r        <= op_nxt;
    now_r       <= now_nxt;
    bytes_r     <= bytes_nxt;
    elapsed_r   <= elapsed_nxt;
    room_r      <= room_nxt;
    plo_r       <= plo_nxt;
    phi_r       <= phi_nxt;
    acc_r       <= acc_nxt;
    elig_r      <= elig_nxt;
    never_r     <= never_nxt;
    conv_q_r    <= conv_q_nxt;
    conv_rem_r  <= conv_rem_nxt;
    avail_out_r <= avail_out_nxt;
    elig_out_r  <= elig_out_nxt;
    never_out_r <= never_out_nxt;
  end

  assign stat = '{
    op:          op_r,
    started:     started_r,
    now_gt_last: (now_r > last_r),
    rate_zero:   (rate_r == '0),
    cap_zero:    (cap_r == '0),
    tok_full:    (tokens_r >= cap_lvl_r),
    bytes_zero:  (bytes_r == '0),
    want_fits:   (plo_r <= {2'b00, tokens_r}),
    div_done:    div_done,
    conv_fit:    (conv_rem_r < {1'b0, SCALE})
  };

  assign out_available_bytes = avail_out_r;
  assign out_eligible_ns     = elig_out_r;
  assign out_never_eligible  = never_out_r;

endmodule

/* hdl/tbrl_ctrl.sv */
module tbrl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tbrl_pkg::dp_stat_t stat,
  output tbrl_pkg::cmd_t     cmd
);
  import tbrl_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DECODE = 15'b000000000000010,
    S_RF_LO  = 15'b000000000000100,
    S_RF_HI  = 15'b000000000001000,
    S_RF_SUM = 15'b000000000010000,
    S_RF_UPD = 15'b000000000100000,
    S_CONS   = 15'b000000001000000,
    S_QCHK   = 15'b000000010000000,
    S_QDIV   = 15'b000000100000000,
    S_QSUM   = 15'b000001000000000,
    S_CONV   = 15'b000010000000000,
    S_CMUL   = 15'b000100000000000,
    S_CSUB   = 15'b001000000000000,
    S_CFIX   = 15'b010000000000000,
    S_FIN    = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = CMD_NONE;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_CAPTURE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_REFILL: begin
            state_nxt = S_CONV;
            if (!stat.started) begin
              cmd = CMD_SET_START;
            end else if (!stat.now_gt_last || stat.rate_zero || stat.cap_zero) begin
              cmd = CMD_TOUCH;
            end else if (stat.tok_full) begin
              cmd = CMD_FILL;
            end else begin
              cmd       = CMD_PREP;
              state_nxt = S_RF_LO;
            end
          end
          OP_CONSUME: begin
            cmd       = CMD_MUL_BYTES;
            state_nxt = S_CONS;
          end
          OP_QUERY: begin
            cmd       = CMD_MUL_BYTES;
            state_nxt = S_QCHK;
          end
          default: begin
            state_nxt = S_CONV;
          end
        endcase
      end
      S_RF_LO: begin
        cmd       = CMD_MUL_LO;
        state_nxt = S_RF_HI;
      end
      S_RF_HI: begin
        cmd       = CMD_MUL_HI;
        state_nxt = S_RF_SUM;
      end
      S_RF_SUM: begin
        cmd       = CMD_SUM;
        state_nxt = S_RF_UPD;
      end
      S_RF_UPD: begin
        cmd       = CMD_RF_UPD;
        state_nxt = S_CONV;
      end
      S_CONS: begin
        cmd       = CMD_CONSUME;
        state_nxt = S_CONV;
      end
      S_QCHK: begin
        if (stat.bytes_zero || stat.want_fits) begin
          cmd       = CMD_Q_NOW;
          state_nxt = S_CONV;
        end else if (stat.rate_zero) begin
          cmd       = CMD_Q_NEVER;
          state_nxt = S_CONV;
        end else begin
          cmd       = CMD_DIV_RATE;
          state_nxt = S_QDIV;
        end
      end
      S_QDIV: begin
        if (stat.div_done) begin
          state_nxt = S_QSUM;
        end
      end
      S_QSUM: begin
        cmd       = CMD_Q_SUM;
        state_nxt = S_CONV;
      end
      S_CONV: begin
        cmd       = CMD_CONV_EST;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        cmd       = CMD_CONV_MUL;
        state_nxt = S_CSUB;
      end
      S_CSUB: begin
        cmd       = CMD_CONV_SUB;
        state_nxt = S_CFIX;
      end
      S_CFIX: begin
        if (stat.conv_fit) begin
          state_nxt = S_FIN;
        end else begin
          cmd = CMD_CONV_FIX;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd           = CMD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/token_bucket_rate_limiter_top.sv */
// Byte token bucket. Tokens are kept exactly as bytes x 1e9, refilled by
// elapsed ns x rate and capped at capacity x 1e9. One item is in flight at a
// time; a result sits in the output register while the next item is taken.
// Opcode 3 and a refill that only moves the time go from decode straight
// to the conversion; consume and query first scale the bytes by 1e9, a
// refill that adds tokens runs two multiplies, a sum and an update, and a
// query that has to wait runs the one-bit-per-cycle divider (62 steps for
// deficit / rate). The bytes-available conversion on every item is a
// reciprocal multiply with a correction loop until the remainder fits. A
// stalled result holds the next item in its last state. The user must write
// registers only while no item is in flight; the block does not enforce it.
// Any write reloads the bucket full and clears the started flag.
module token_bucket_rate_limiter_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tbrl_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tbrl_pkg::DATA_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tbrl_pkg::OP_W-1:0]   in_opcode,
  input  logic [tbrl_pkg::TIME_W-1:0] in_now_ns,
  input  logic [tbrl_pkg::DATA_W-1:0] in_byte_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tbrl_pkg::DATA_W-1:0] out_available_bytes,
  output logic [tbrl_pkg::TIME_W-1:0] out_eligible_ns,
  output logic                        out_never_eligible
);
  import tbrl_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  tbrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tbrl_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_opcode           (in_opcode),
    .in_now_ns           (in_now_ns),
    .in_byte_count       (in_byte_count),
    .out_available_bytes (out_available_bytes),
    .out_eligible_ns     (out_eligible_ns),
    .out_never_eligible  (out_never_eligible)
  );

  a_busy_after_transfer: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input side not busy after a transfer");

  a_result_from_work: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall)
  ) else $error("result appeared without an item in flight");

  a_never_saturates: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_never_eligible) |-> (out_eligible_ns == TIME_MAX)
  ) else $error("never-eligible result without saturated time");

endmodule

/* tb/sv/token_bucket_rate_limiter_top_test.sv */
module token_bucket_rate_limiter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tbrl_pkg::*;

  localparam logic [63:0] NS_SCALE       = 64'd1000000000;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned PHASES          = 9;

  typedef struct {
    logic [DATA_W-1:0] avail;
    logic [TIME_W-1:0] elig;
    logic              never;
  } bucket_report_t;

  class bucket_scoreboard;
    logic [DATA_W-1:0] rate;
    logic [DATA_W-1:0] cap;
    logic [63:0]       tokens;
    logic [TIME_W-1:0] last_ns;
    bit                started;
    bucket_report_t    reports_due[$];
    int                errors;

    function new();
      rate    = '0;
      cap     = '0;
      tokens  = '0;
      last_ns = '0;
      started = 1'b0;
      errors  = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      if (idx == REG_RATE) begin
        rate = val;
      end else begin
        cap = val;
      end
      tokens  = {32'd0, cap} * NS_SCALE;
      last_ns = '0;
      started = 1'b0;
    endfunction

    function void refill(logic [TIME_W-1:0] t);
      logic [63:0] elapsed;
      logic [63:0] full;
      logic [63:0] room;
      if (!started) begin
        last_ns = t;
        started = 1'b1;
      end else if (t <= last_ns || rate == 0 || cap == 0) begin
        if (t > last_ns) begin
          last_ns = t;
        end
      end else begin
        elapsed = {1'b0, t - last_ns};
        full    = {32'd0, cap} * NS_SCALE;
        if (tokens >= full) begin
          tokens = full;
        end else begin
          room = full - tokens;
          if (elapsed > room / {32'd0, rate}) begin
            tokens = full;
          end else begin
            tokens = tokens + elapsed * {32'd0, rate};
          end
        end
        last_ns = t;
      end
    endfunction

    function void note_item(opcode_t op, logic [TIME_W-1:0] t, logic [DATA_W-1:0] n);
      logic [63:0] want;
      logic [63:0] deficit;
      logic [63:0] wait_ns;
      logic [63:0] sum;
      logic [63:0] whole;
      bucket_report_t r;
      r.elig  = '0;
      r.never = 1'b0;
      want    = {32'd0, n} * NS_SCALE;
      case (op)
        OP_REFILL: begin
          refill(t);
        end
        OP_CONSUME: begin
          tokens = (want >= tokens) ? 64'd0 : tokens - want;
        end
        OP_QUERY: begin
          if (n == 0 || want <= tokens) begin
            r.elig = t;
          end else if (rate == 0) begin
            r.never = 1'b1;
            r.elig  = TIME_MAX;
          end else begin
            deficit = want - tokens;
            wait_ns = deficit / {32'd0, rate};
            if (deficit % {32'd0, rate} != 0) begin
              wait_ns = wait_ns + 64'd1;
            end
            if (wait_ns < 1) begin
              wait_ns = 64'd1;
            end
            sum = {1'b0, t} + wait_ns;
            r.elig = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
          end
        end
        default: begin
        end
      endcase
      whole   = tokens / NS_SCALE;
      r.avail = whole[DATA_W-1:0];
      reports_due.push_back(r);
    endfunction

    function void check_result(logic [DATA_W-1:0] avail, logic [TIME_W-1:0] elig,
                               logic never);
      bucket_report_t r;
      if (reports_due.size() == 0) begin
        $error("unexpected result transfer: available_bytes %0d eligible_ns %0d", avail, elig);
        errors++;
        return;
      end
      r = reports_due.pop_front();
      if (avail !== r.avail) begin
        $error("available_bytes: expected %0d, got %0d", r.avail, avail);
        errors++;
      end
      if (elig !== r.elig) begin
        $error("eligible_ns: expected %0d, got %0d", r.elig, elig);
        errors++;
      end
      if (never !== r.never) begin
        $error("never_eligible: expected %0d, got %0d", r.never, never);
        errors++;
      end
    endfunction
  endclass

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              cfg_we        = 1'b0;
  logic [IDX_W-1:0]  cfg_index     = '0;
  logic [DATA_W-1:0] cfg_wdata     = '0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode     = '0;
  logic [TIME_W-1:0] in_now_ns     = '0;
  logic [DATA_W-1:0] in_byte_count = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [DATA_W-1:0] out_available_bytes;
  logic [TIME_W-1:0] out_eligible_ns;
  logic              out_never_eligible;

  int unsigned       idle_pct      = 0;
  int unsigned       quiet_cycles  = 0;
  logic [TIME_W-1:0] clock_ns      = '0;
  bucket_scoreboard  bucket;

  token_bucket_rate_limiter_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_now_ns           (in_now_ns),
    .in_byte_count       (in_byte_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_available_bytes (out_available_bytes),
    .out_eligible_ns     (out_eligible_ns),
    .out_never_eligible  (out_never_eligible)
  );

  always #5 clk = ~clk;

  always begin
    @(posedge clk);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 18)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      bucket.check_result(out_available_bytes, out_eligible_ns, out_never_eligible);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(input opcode_t op, input logic [TIME_W-1:0] t,
                           input logic [DATA_W-1:0] n);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_now_ns     <= t;
    in_byte_count <= n;
    do @(posedge clk); while (in_stall);
    bucket.note_item(op, t, n);
  endtask

  // drop valid and let every outstanding result transfer complete
  task automatic settle();
    in_valid <= 1'b0;
    while (bucket.reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    bucket.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_bucket(input logic [DATA_W-1:0] rate_v,
                                input logic [DATA_W-1:0] cap_v);
    settle();
    repeat (4) @(posedge clk);
    if ($urandom_range(0, 1) == 1) begin
      cfg_write(REG_RATE, rate_v);
      cfg_write(REG_CAP, cap_v);
    end else begin
      cfg_write(REG_CAP, cap_v);
      cfg_write(REG_RATE, rate_v);
    end
  endtask

  task automatic run_phase(input int unsigned count, input bit pause_midway);
    int unsigned       pick;
    int unsigned       span;
    logic [63:0]       jump;
    opcode_t           op;
    logic [TIME_W-1:0] t;
    logic [DATA_W-1:0] n;
    span = (bucket.cap < 100000) ? bucket.cap + 16 : 100000;
    for (int unsigned k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) begin
        settle();
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        op = OP_REFILL;
      end else if (pick < 65) begin
        op = OP_CONSUME;
      end else if (pick < 95) begin
        op = OP_QUERY;
      end else begin
        op = OP_NOP;
      end
      jump = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        clock_ns = clock_ns + TIME_W'($urandom_range(0, 2000));
      end else if (pick < 68) begin
        clock_ns = clock_ns + TIME_W'(jump[35:0]);
      end
      t = clock_ns;
      // odd times mostly on non-refill ops so refills keep moving forward
      if (op != OP_REFILL || $urandom_range(0, 7) == 0) begin
        if (pick >= 68 && pick < 76) begin
          t = clock_ns - TIME_W'($urandom_range(1, 800));
        end else if (pick >= 76 && pick < 81) begin
          t = jump[TIME_W-1:0];
        end else if (pick >= 81 && pick < 85) begin
          t = TIME_MAX - TIME_W'($urandom_range(0, 3000));
        end
      end
      if (op == OP_REFILL && t > clock_ns && pick < 81) begin
        clock_ns = t;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        n = $urandom_range(0, span);
      end else if (pick < 80) begin
        n = $urandom_range(0, 64);
      end else begin
        n = $urandom;
      end
      send_item(op, t, n);
    end
  endtask

  initial begin
    logic [DATA_W-1:0] rate_v;
    logic [DATA_W-1:0] cap_v;
    bucket = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 10;
    send_item(OP_QUERY, '0, '0);
    send_item(OP_QUERY, 63'd100, 32'd5);
    send_item(OP_REFILL, 63'd50, '0);
    send_item(OP_REFILL, 63'd200, '0);
    send_item(OP_NOP, TIME_MAX, '1);

    program_bucket(32'd100000000, 32'd1000);
    send_item(OP_REFILL, 63'd1000, '0);
    send_item(OP_CONSUME, '0, 32'd600);
    send_item(OP_REFILL, 63'd500, '0);
    send_item(OP_REFILL, 63'd1000, '0);
    send_item(OP_REFILL, 63'd2000, '0);
    send_item(OP_QUERY, 63'd2000, 32'd500);
    send_item(OP_QUERY, 63'd2000, 32'd501);
    send_item(OP_CONSUME, '0, 32'd5000);
    send_item(OP_QUERY, 63'd2000, '0);
    send_item(OP_REFILL, TIME_MAX - 63'd10, '0);
    send_item(OP_CONSUME, '0, 32'd1000);
    send_item(OP_QUERY, TIME_MAX - 63'd3, '1);
    send_item(OP_QUERY, TIME_MAX, 32'd1);

    program_bucket('1, '1);
    send_item(OP_CONSUME, '0, '1);
    send_item(OP_REFILL, 63'd1, '0);
    send_item(OP_REFILL, 63'd2, '0);
    send_item(OP_QUERY, 63'd2, 32'd5);
    send_item(OP_REFILL, '0, '0);
    send_item(OP_CONSUME, '0, '0);

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          rate_v = '0;
          cap_v  = $urandom_range(100, 5000);
        end
        1: begin
          rate_v = '1;
          cap_v  = '1;
        end
        2: begin
          rate_v = $urandom_range(1000000, 2000000000);
          cap_v  = '0;
        end
        3: begin
          rate_v = 32'd1;
          cap_v  = $urandom_range(10, 1000);
        end
        default: begin
          rate_v = $urandom_range(1000000, 32'd4000000000);
          cap_v  = $urandom_range(50, 50000);
        end
      endcase
      program_bucket(rate_v, cap_v);
      clock_ns = TIME_W'($urandom_range(0, 100000));
      if (p == PHASES - 1) begin
        idle_pct = 0;
      end else if (p == 0) begin
        idle_pct = 20;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 5;
          2: idle_pct = 15;
          default: idle_pct = 30;
        endcase
      end
      run_phase(ITEMS_PER_PHASE, p % 3 == 1);
    end

    settle();
    repeat (120) @(posedge clk);
    if (bucket.errors == 0 && bucket.reports_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
